FILE: design/bpa_pkg.sv
// Shared constants and types for the bitmap page allocator.
`default_nettype none
package bpa_pkg;
    localparam int MAX_PAGES  = 65536;
    localparam int WORD_W     = 32;
    localparam int OFF_W      = $clog2(WORD_W);
    localparam int MAP_DEPTH  = MAX_PAGES / WORD_W;
    localparam int WADDR_W    = $clog2(MAP_DEPTH);
    localparam int POS_W      = $clog2(MAX_PAGES) + 1;
    localparam int PAGE_W     = 16;
    localparam int CNT_W      = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [POS_W-1:0] PAGE_LIMIT = POS_W'(MAX_PAGES);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_AVAIL = 2'd2,
        OP_NONE  = 2'd3
    } op_t;
endpackage
`default_nettype wire

FILE: design/bitmap_page_allocator.sv
// Top level: next-fit page allocator over a word-organized used/free bitmap.
//
//  channel   signals                                  handshake
//  --------  ---------------------------------------  -----------------------
//  command   operation, first_page, page_count        start && !busy
//  result    status, start_page, pages_allocated      done (one-cycle strobe)
//  config    cfg_wdata (total_pages)                  cfg_we
//
// After reset a fill pass writes all-ones into the 2048-word bitmap, one word
// per cycle; busy stays high meanwhile.
// Allocate reads each bitmap word and then checks its pages one per cycle,
// then sets the found run with a read and a write per word touched.
// Free / make available do a read and a write per word in the range.
// An unused opcode is answered from idle with no bitmap access. The receiver cannot stall results.
`default_nettype none
module bitmap_page_allocator (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 operation,
    input  wire logic [bpa_pkg::PAGE_W-1:0] first_page,
    input  wire logic [bpa_pkg::CNT_W-1:0]  page_count,
    output logic                            done,
    output logic                            status,
    output logic      [bpa_pkg::PAGE_W-1:0] start_page,
    output logic      [bpa_pkg::CNT_W-1:0]  pages_allocated,
    input  wire logic                       cfg_we,
    input  wire logic [bpa_pkg::CNT_W-1:0]  cfg_wdata
);
    import bpa_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_RD, ST_CHK, ST_FRD, ST_FWR
    } state_t;

    state_t             state_reg;
    logic [WADDR_W-1:0] init_addr_reg;
    logic [POS_W-1:0]   pos_reg, limit_reg, run_reg, need_reg, last_reg;
    logic [POS_W-1:0]   scan_reg, cur_reg, hi_reg;
    logic               pass_reg, set_reg, done_reg, status_reg;
    logic [PAGE_W-1:0]  start_page_reg;
    logic [CNT_W-1:0]   total_reg, tp_reg;

    // bitmap memory
    logic               ram_we, ram_re;
    logic [WADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata, fill_mask;

    bpa_ram #(.WIDTH(WORD_W), .DEPTH(MAP_DEPTH)) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Effective scan limit: total_pages clamped to the bitmap size.
    logic [POS_W-1:0] page_limit;
    assign page_limit = (POS_W'(tp_reg) > PAGE_LIMIT) ? PAGE_LIMIT : POS_W'(tp_reg);

    // Range end for free / make available, clamped to the bitmap.
    logic [POS_W:0] range_end;
    assign range_end = (POS_W+1)'(first_page) + (POS_W+1)'(page_count);

    logic [POS_W-1:0] pos_inc, run_inc, cur_next;
    logic [CNT_W:0]   sum_total;
    logic             page_used;
    assign pos_inc   = pos_reg + POS_W'(1);
    assign run_inc   = run_reg + POS_W'(1);
    assign cur_next  = {cur_reg[POS_W-1:OFF_W] + (POS_W-OFF_W)'(1), OFF_W'(0)};
    assign sum_total = (CNT_W+1)'(total_reg) + (CNT_W+1)'(need_reg);
    assign page_used = ram_rdata[pos_reg[OFF_W-1:0]];

    // Per-bit mask of pages in [cur, hi) inside the current word.
    always_comb
    begin
        logic [POS_W-1:0] pg;
        for (int i = 0; i < WORD_W; i++)
        begin
            pg = {cur_reg[POS_W-1:OFF_W], OFF_W'(i)};
            fill_mask[i] = (pg >= cur_reg) && (pg < hi_reg);
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg[OFF_W+WADDR_W-1:OFF_W];
        ram_wdata = set_reg ? (ram_rdata | fill_mask) : (ram_rdata & ~fill_mask);
        ram_re    = 1'b0;
        ram_raddr = pos_reg[OFF_W+WADDR_W-1:OFF_W];
        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = init_addr_reg;
                ram_wdata = '1;
            end
            ST_RD:  ram_re = (pos_reg < limit_reg);
            ST_FRD:
            begin
                ram_re    = 1'b1;
                ram_raddr = cur_reg[OFF_W+WADDR_W-1:OFF_W];
            end
            ST_FWR: ram_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            init_addr_reg  <= '0;
            pos_reg        <= '0;
            limit_reg      <= '0;
            run_reg        <= '0;
            need_reg       <= '0;
            last_reg       <= '0;
            scan_reg       <= '0;
            cur_reg        <= '0;
            hi_reg         <= '0;
            pass_reg       <= 1'b0;
            set_reg        <= 1'b0;
            total_reg      <= '0;
            tp_reg         <= CNT_W'(MAX_PAGES);
            done_reg       <= 1'b0;
            status_reg     <= 1'b0;
            start_page_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                tp_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_INIT:
                begin
                    init_addr_reg <= init_addr_reg + WADDR_W'(1);
                    if (init_addr_reg == WADDR_W'(MAP_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        status_reg     <= 1'b0;
                        start_page_reg <= '0;
                        need_reg       <= POS_W'(page_count);
                        cur_reg        <= POS_W'(first_page);
                        hi_reg         <= (range_end > (POS_W+1)'(PAGE_LIMIT)) ?
                                          PAGE_LIMIT : range_end[POS_W-1:0];
                        set_reg        <= 1'b0;
                        priority case (op_t'(operation))
                            OP_ALLOC:
                            begin
                                pos_reg   <= scan_reg;
                                last_reg  <= scan_reg;
                                limit_reg <= page_limit;
                                run_reg   <= '0;
                                pass_reg  <= 1'b0;
                                if (page_count == '0)
                                begin
                                    status_reg <= 1'b1;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_RD;
                                end
                            end
                            OP_FREE:
                            begin
                                if (POS_W'(first_page) < scan_reg)
                                begin
                                    scan_reg <= POS_W'(first_page);
                                end
                                total_reg <= (total_reg > page_count) ?
                                             total_reg - page_count : '0;
                                if (page_count == '0)
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_FRD;
                                end
                            end
                            OP_AVAIL:
                            begin
                                if (page_count == '0)
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_FRD;
                                end
                            end
                            default: done_reg <= 1'b1;
                        endcase
                    end
                end
                ST_RD:
                begin
                    if (pos_reg < limit_reg)
                    begin
                        state_reg <= ST_CHK;
                    end
                    else if (!pass_reg)
                    begin
                        // wrap: rescan from page 0 up to the old position
                        pass_reg  <= 1'b1;
                        pos_reg   <= '0;
                        limit_reg <= last_reg;
                        run_reg   <= '0;
                    end
                    else
                    begin
                        status_reg <= 1'b1;
                        done_reg   <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                ST_CHK:
                begin
                    pos_reg <= pos_inc;
                    if (page_used)
                    begin
                        run_reg <= '0;
                    end
                    else
                    begin
                        run_reg <= run_inc;
                    end
                    if (!page_used && run_inc == need_reg)
                    begin
                        // found: mark [pos+1-need, pos+1) used
                        scan_reg       <= pos_inc;
                        cur_reg        <= pos_inc - need_reg;
                        hi_reg         <= pos_inc;
                        set_reg        <= 1'b1;
                        start_page_reg <= PAGE_W'(pos_inc - need_reg);
                        total_reg      <= (sum_total > (CNT_W+1)'(CNT_MAX)) ?
                                          CNT_MAX : sum_total[CNT_W-1:0];
                        state_reg      <= ST_FRD;
                    end
                    else if (pos_inc >= limit_reg || pos_reg[OFF_W-1:0] == '1)
                    begin
                        state_reg <= ST_RD;
                    end
                end
                ST_FRD: state_reg <= ST_FWR;
                ST_FWR:
                begin
                    cur_reg <= cur_next;
                    if (cur_next >= hi_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_FRD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign start_page      = start_page_reg;
    assign pages_allocated = total_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result strobe while busy");
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done) else $error("accepted command lost");
    a_oom_total: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> pages_allocated == $past(pages_allocated))
        else $error("allocation total changed on out of memory");
    a_oom_start: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> start_page == '0) else $error("start page on failure");
`endif
endmodule
`default_nettype wire

FILE: design/bpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire
